// ----- rtl/core/packet_filter_crc8_framer_core_macros.svh -----
// Assertion helpers shared by the framer core files.
// Each macro expands to one labelled concurrent assertion, sampled on the
// rising clock and disabled while the asynchronous reset is asserted.
`ifndef PACKET_FILTER_CRC8_FRAMER_CORE_MACROS_SVH
`define PACKET_FILTER_CRC8_FRAMER_CORE_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define PFCF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication: cons must hold in the cycle after the one in which ante holds.
`define PFCF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/pfcf_pkg.sv -----
// ----------------------------------------------------------------------------
// pfcf_pkg
// Types, constants and the CRC-8 step shared by the framer core modules.
// ----------------------------------------------------------------------------
package pfcf_pkg;

	localparam logic [7:0] SYNC_FIRST  = 8'hAA;
	localparam logic [7:0] SYNC_SECOND = 8'h55;
	localparam logic [7:0] CRC_POLY    = 8'h07;
	localparam logic [7:0] CRC_TOP     = 8'h80;

	localparam logic [7:0] MAGIC_RESET   = 8'h00;
	localparam logic [7:0] MIN_LEN_RESET = 8'd8;

	// Configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_MAGIC   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_LEN = 1'd1;

	// Command queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [7:0] data_byte;
		logic       start_of_packet;
		logic       end_of_packet;
		logic [7:0] packet_length;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       end_of_frame;
	} result_t;

	// One accepted byte that yields output: optional header, the byte,
	// optional CRC trailer.
	typedef struct packed {
		logic       hdr;
		logic [7:0] len;
		logic [7:0] data;
		logic       tail;
		logic [7:0] crc;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_SYNC1,
		ST_SYNC2,
		ST_LEN,
		ST_DATA,
		ST_CRC
	} state_t;

	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if ((c & CRC_TOP) != 8'h00) begin
				c = (c << 1) ^ CRC_POLY;
			end else begin
				c = c << 1;
			end
		end
		return c;
	endfunction

endpackage

// ----- rtl/core/pfcf_front.sv -----
// ----------------------------------------------------------------------------
// pfcf_front
// Holds configuration, tracks packet state, filters and queues commands.
// ----------------------------------------------------------------------------
module pfcf_front import pfcf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data,
	input  logic                 push,
	input  item_t                item,
	input  logic                 q_full,
	output logic                 q_wr,
	output cmd_t                 q_wr_data
);

	logic [7:0] magic_q;
	logic [7:0] min_len_q;
	logic [7:0] crc_q;
	logic       dropping_q;
	logic       inside_q;

	logic       accept;
	logic       active;
	logic       drop_new;
	logic [7:0] crc_next;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q   <= MAGIC_RESET;
			min_len_q <= MIN_LEN_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_MAGIC:   magic_q   <= cfg_data;
				REG_MIN_LEN: min_len_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign accept   = push && !q_full;
	assign active   = item.start_of_packet || inside_q;
	assign drop_new = item.start_of_packet
		? ((item.packet_length < min_len_q) || (item.data_byte != magic_q))
		: dropping_q;
	assign crc_next = crc8_update(item.start_of_packet ? 8'h00 : crc_q, item.data_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q      <= 8'h00;
			dropping_q <= 1'b0;
			inside_q   <= 1'b0;
		end else if (accept && active) begin
			if (!drop_new) begin
				crc_q <= crc_next;
			end else if (item.start_of_packet) begin
				crc_q <= 8'h00;
			end
			if (item.end_of_packet) begin
				inside_q   <= 1'b0;
				dropping_q <= 1'b0;
			end else begin
				inside_q   <= 1'b1;
				dropping_q <= drop_new;
			end
		end
	end

	assign q_wr           = accept && active && !drop_new;
	assign q_wr_data.hdr  = item.start_of_packet;
	assign q_wr_data.len  = item.packet_length;
	assign q_wr_data.data = item.data_byte;
	assign q_wr_data.tail = item.end_of_packet;
	assign q_wr_data.crc  = crc_next;

endmodule

// ----- rtl/core/pfcf_queue.sv -----
// ----------------------------------------------------------------------------
// pfcf_queue
// Short command queue that decouples the front from the back.
// ----------------------------------------------------------------------------
`include "packet_filter_crc8_framer_core_macros.svh"

module pfcf_queue import pfcf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  cmd_t wr_data,
	output logic full,
	input  logic rd_en,
	output cmd_t rd_data,
	output logic rd_valid
);

	cmd_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full     = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`PFCF_ASSERT_IMP(a_no_overfill, clk, arst_n, wr_en, !full, "queue written while full")
	`PFCF_ASSERT_IMP(a_no_underrun, clk, arst_n, rd_en, rd_valid, "queue read while empty")
	`PFCF_ASSERT_NXT(a_count_tracks, clk, arst_n, wr_en && !rd_en, count_q != '0,
		"queue count lost a write")

endmodule

// ----- rtl/core/pfcf_back.sv -----
// ----------------------------------------------------------------------------
// pfcf_back
// Expands queued commands into framed words through an output register.
// ----------------------------------------------------------------------------
`include "packet_filter_crc8_framer_core_macros.svh"

module pfcf_back import pfcf_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    head_valid,
	input  cmd_t    head,
	output logic    head_pop,
	input  logic    pop,
	output logic    empty,
	output result_t result
);

	state_t  state_q;
	logic    started_q;
	result_t out_q;
	logic    out_valid_q;

	state_t  cur_state;
	state_t  next_state;
	logic    step;
	logic    done;
	result_t word;

	assign step = head_valid && (!out_valid_q || pop);

	always_comb begin
		cur_state  = started_q ? state_q : (head.hdr ? ST_SYNC1 : ST_DATA);
		next_state = ST_DATA;
		done       = 1'b0;
		word       = '{out_byte: head.data, end_of_frame: 1'b0};
		unique case (cur_state)
			ST_SYNC1: begin
				word.out_byte = SYNC_FIRST;
				next_state    = ST_SYNC2;
			end
			ST_SYNC2: begin
				word.out_byte = SYNC_SECOND;
				next_state    = ST_LEN;
			end
			ST_LEN: begin
				word.out_byte = head.len;
				next_state    = ST_DATA;
			end
			ST_DATA: begin
				word.out_byte = head.data;
				next_state    = ST_CRC;
				done          = !head.tail;
			end
			ST_CRC: begin
				word.out_byte     = head.crc;
				word.end_of_frame = 1'b1;
				done              = 1'b1;
			end
			default: begin
				done = 1'b1;
			end
		endcase
	end

	assign head_pop = step && done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_SYNC1;
			started_q <= 1'b0;
		end else if (step) begin
			state_q   <= next_state;
			started_q <= !done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_q <= word;
		end
	end

	assign empty  = !out_valid_q;
	assign result = out_q;

	`PFCF_ASSERT_NXT(a_crc_marks_eof, clk, arst_n, step && cur_state == ST_CRC,
		out_valid_q && out_q.end_of_frame, "CRC word not marked as end of frame")
	`PFCF_ASSERT_NXT(a_sync_first, clk, arst_n, step && cur_state == ST_SYNC1,
		out_q.out_byte == SYNC_FIRST, "first sync byte wrong")
	`PFCF_ASSERT_IMP(a_pop_on_last, clk, arst_n, head_pop,
		cur_state == ST_CRC || (cur_state == ST_DATA && !head.tail),
		"command released before its last word")

endmodule

// ----- rtl/core/packet_filter_crc8_framer_core.sv -----
// ----------------------------------------------------------------------------
// packet_filter_crc8_framer_core
// Packet filter and sync/length/CRC-8 framer, one byte per word.
// ----------------------------------------------------------------------------
// Bytes enter as words on the push/full side, one word per cycle while full
// is low. A packet whose first word has start_of_packet set is checked
// against the magic value (its first byte) and the minimum length (its
// declared packet_length); a failing packet is dropped up to and including
// its end-of-packet word, and words outside any packet are ignored. A
// passing packet leaves on the empty/pop side as 0xAA, 0x55, the length, the
// payload bytes and a CRC-8 (poly 0x07, init 0x00, MSB first) over the
// payload, with end_of_frame set on the CRC word only. A new start mark
// inside an open packet abandons that packet without a CRC word. The output
// side delivers one word per cycle while pop keeps up, and a passing packet
// of N bytes yields N + 4 words: three header words, the payload and the
// CRC word. Input runs at one word per cycle until the four-entry command
// queue fills; the header and CRC words of passing packets let the output
// fall behind the input, so back-to-back passing packets can fill the queue
// and stall the input, and a held-off pop stalls it for as long as the hold
// lasts. From an idle block, the first framed word of an accepted byte
// passes through the command queue and then the output register before it
// reaches the result ports. The output register holds a finished word until
// it is popped and can be reloaded in the cycle it is popped. Configuration
// writes (index 0 magic value, index 1 minimum length) are always ready and
// take effect on the next word; write them only while the block is idle.
// ----------------------------------------------------------------------------
module packet_filter_crc8_framer_core import pfcf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration write channel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data,
	// packet bytes in
	input  logic                 push,
	output logic                 full,
	input  item_t                item,
	// framed bytes out
	output logic                 empty,
	input  logic                 pop,
	output result_t              result
);

	// Front-to-queue and queue-to-back command traffic
	logic q_wr;
	cmd_t q_wr_data;
	logic q_full;
	logic q_rd;
	cmd_t q_rd_data;
	logic q_rd_valid;

	// Filter and classify each accepted word; hold packet state and CRC
	pfcf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.item      (item),
		.q_full    (q_full),
		.q_wr      (q_wr),
		.q_wr_data (q_wr_data)
	);

	// Decouple the two sides so the header burst does not stall the input at once
	pfcf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (q_wr),
		.wr_data  (q_wr_data),
		.full     (q_full),
		.rd_en    (q_rd),
		.rd_data  (q_rd_data),
		.rd_valid (q_rd_valid)
	);

	// Expand each command into its framed words, one per cycle while pop keeps up
	pfcf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_rd_valid),
		.head       (q_rd_data),
		.head_pop   (q_rd),
		.pop        (pop),
		.empty      (empty),
		.result     (result)
	);

	// Back-pressure the input only when the command queue is full
	assign full = q_full;

endmodule

// ----- tb/tb_packet_filter_crc8_framer_core.sv -----
// ----------------------------------------------------------------------------
// tb_packet_filter_crc8_framer_core
// Self-checking bench for the packet filter and CRC-8 framer core.
// ----------------------------------------------------------------------------
// Packet bytes go in as words on the push/full side. A behavioural model of
// the filter and framer predicts the framed words that each accepted word
// should cause. A separate receiver pops words at random and checks each one,
// field by field, against the oldest prediction. Directed tests cover the
// reset settings, single-byte frames, abandoned packets, stray words, length
// mismatches, a zero minimum and the field extremes. A hold-off test fills
// the block and stalls its input. Random phases then run mostly well-formed
// packets, with broken packets and noise mixed in, under several register
// settings.
// ----------------------------------------------------------------------------
module tb_packet_filter_crc8_framer_core;
	import pfcf_pkg::*;

	localparam int RUN_LIMIT     = 2_000_000;
	localparam int HOLD_CYCLES   = 80;
	localparam int SETTLE_CYCLES = 8;
	localparam int IDLE_PCT      = 18;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [7:0]           cfg_data;
	logic                 push;
	logic                 full;
	item_t                item;
	logic                 empty;
	logic                 pop;
	result_t              result;

	// Model copy of the registers and of the packet state
	logic [7:0] magic_reg;
	logic [7:0] min_len_reg;
	logic [7:0] crc_acc;
	logic       drop_pkt;
	logic       in_pkt;

	// Framed words predicted but not yet popped, oldest first
	result_t expected_words[$];

	int errors   = 0;
	bit gaps_on  = 1'b1;
	bit hold_req = 1'b0;

	packet_filter_crc8_framer_core i_dut (.*);

	initial begin : clock_gen
		forever #2 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Behavioural model
	// ------------------------------------------------------------------------

	// Shift one byte into the CRC, MSB first, one bit per step.
	function automatic logic [7:0] crc8_next(input logic [7:0] acc, input logic [7:0] b);
		logic [7:0] r;
		logic       fb;
		r = acc;
		for (int k = 7; k >= 0; k--) begin
			fb = r[7] ^ b[k];
			r  = {r[6:0], 1'b0};
			if (fb) begin
				r = r ^ CRC_POLY;
			end
		end
		return r;
	endfunction

	function void note_word(input logic [7:0] b, input logic eof);
		result_t w;
		w.out_byte     = b;
		w.end_of_frame = eof;
		expected_words.push_back(w);
	endfunction

	// Predict the framed words caused by one accepted input word.
	function void frame_model(input item_t it);
		if (it.start_of_packet) begin
			// a start mark always opens a fresh packet, abandoning any open one
			in_pkt   = 1'b1;
			crc_acc  = 8'h00;
			drop_pkt = (it.packet_length < min_len_reg) || (it.data_byte != magic_reg);
			if (!drop_pkt) begin
				note_word(SYNC_FIRST, 1'b0);
				note_word(SYNC_SECOND, 1'b0);
				note_word(it.packet_length, 1'b0);
			end
		end else if (!in_pkt) begin
			// stray word outside any packet: nothing comes out
			return;
		end
		if (!drop_pkt) begin
			crc_acc = crc8_next(crc_acc, it.data_byte);
			note_word(it.data_byte, 1'b0);
			if (it.end_of_packet) begin
				note_word(crc_acc, 1'b1);
			end
		end
		if (it.end_of_packet) begin
			in_pkt   = 1'b0;
			drop_pkt = 1'b0;
		end
	endfunction

	// ------------------------------------------------------------------------
	// Receiver and checker
	// ------------------------------------------------------------------------
	// Sample at the rising edge, so empty, pop and result are the values the
	// block saw at that edge. Then choose pop for the next cycle: hold it low
	// for a counted stretch when a hold-off is requested, else idle at random.
	initial begin : word_receiver
		int      hold_left;
		result_t got;
		result_t want;
		hold_left = 0;
		pop <= 1'b0;
		forever begin
			@(posedge clk);
			if (pop === 1'b1 && empty === 1'b0) begin
				got = result;
				if (expected_words.size() == 0) begin
					$display("%0t: unexpected word: expected none, actual byte %h eof %b",
						$time, got.out_byte, got.end_of_frame);
					errors++;
				end else begin
					want = expected_words.pop_front();
					if (got.out_byte !== want.out_byte) begin
						$display("%0t: out_byte mismatch: expected %h, actual %h",
							$time, want.out_byte, got.out_byte);
						errors++;
					end
					if (got.end_of_frame !== want.end_of_frame) begin
						$display("%0t: end_of_frame mismatch: expected %b, actual %b",
							$time, want.end_of_frame, got.end_of_frame);
						errors++;
					end
				end
			end
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req  = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if (gaps_on) begin
				pop <= ($urandom_range(99) >= IDLE_PCT);
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Sender helpers
	// ------------------------------------------------------------------------

	function automatic item_t mk_item(input logic [7:0] d, input logic sop, input logic eop,
		input logic [7:0] len);
		item_t it;
		it.data_byte       = d;
		it.start_of_packet = sop;
		it.end_of_packet   = eop;
		it.packet_length   = len;
		return it;
	endfunction

	// Offer one word and hold it until the block takes it. Leave push high on
	// return, so back-to-back words keep it high without a dip.
	task automatic send_byte(input item_t it);
		if (gaps_on) begin
			while ($urandom_range(99) < IDLE_PCT) begin
				push <= 1'b0;
				@(posedge clk);
			end
		end
		push <= 1'b1;
		item <= it;
		@(posedge clk);
		while (full !== 1'b0) begin
			@(posedge clk);
		end
		frame_model(it);
	endtask

	// Send a whole packet: the given first byte and declared length, random
	// payload after it, end mark on the last word.
	task automatic send_packet(input logic [7:0] first, input int n, input logic [7:0] declared);
		logic [7:0] b;
		logic [7:0] junk_len;
		for (int k = 0; k < n; k++) begin
			if (k == 0) begin
				send_byte(mk_item(first, 1'b1, n == 1, declared));
			end else begin
				b        = 8'($urandom_range(255));
				junk_len = 8'($urandom_range(255));
				send_byte(mk_item(b, 1'b0, k == n - 1, junk_len));
			end
		end
	endtask

	// Drop push, wait for every predicted word, then let dropped words drain.
	task automatic settle();
		push <= 1'b0;
		while (expected_words.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (cfg_ready !== 1'b1) begin
			@(posedge clk);
		end
		cfg_valid <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_MAGIC: begin
				magic_reg = val;
			end
			REG_MIN_LEN: begin
				min_len_reg = val;
			end
			default: begin
			end
		endcase
	endtask

	task automatic configure(input logic [7:0] magic, input logic [7:0] min_len);
		settle();
		write_reg(REG_MAGIC, magic);
		write_reg(REG_MIN_LEN, min_len);
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Reset settings: magic 0x00, minimum length 8.
	task automatic check_reset_settings();
		send_packet(8'h00, 2, 8'd8);
		send_packet(8'h00, 1, 8'd7);
		send_packet(8'h01, 2, 8'd9);
	endtask

	// Start and end on the same word: header, byte and CRC, or nothing.
	task automatic check_single_byte_frames();
		configure(8'h00, 8'd1);
		send_packet(8'h00, 1, 8'd1);
		send_packet(8'h80, 1, 8'd1);
	endtask

	// A new start mark inside an open packet abandons it without a CRC word.
	task automatic check_abandoned_packet();
		send_byte(mk_item(8'h00, 1'b1, 1'b0, 8'd3));
		send_byte(mk_item(8'h3C, 1'b0, 1'b0, 8'd0));
		send_packet(8'h00, 3, 8'd3);
	endtask

	// Words outside any packet, with or without an end mark, are ignored.
	task automatic check_stray_bytes();
		send_byte(mk_item(8'hC3, 1'b0, 1'b0, 8'hFF));
		send_byte(mk_item(8'h5A, 1'b0, 1'b1, 8'h00));
	endtask

	// Declared length is passed on as given, whatever the real byte count.
	task automatic check_length_mismatch();
		send_packet(8'h00, 2, 8'd255);
		send_packet(8'h00, 3, 8'd1);
	endtask

	// With a zero minimum even a declared length of zero passes.
	task automatic check_zero_minimum();
		configure(8'h00, 8'd0);
		send_packet(8'h00, 1, 8'd0);
	endtask

	// Top magic and top minimum: only a declared length of 255 gets through.
	task automatic check_field_extremes();
		configure(8'hFF, 8'd255);
		send_byte(mk_item(8'hFF, 1'b1, 1'b0, 8'hFF));
		send_byte(mk_item(8'h00, 1'b0, 1'b0, 8'h00));
		send_byte(mk_item(8'hFF, 1'b0, 1'b1, 8'hFF));
		send_packet(8'hFF, 1, 8'd254);
	endtask

	// Hold the receiver off while a long packet streams in without gaps, so
	// the command queue fills and full stalls the sender.
	task automatic check_backpressure();
		configure(8'hA5, 8'd4);
		gaps_on  = 1'b0;
		hold_req = 1'b1;
		send_packet(8'hA5, 30, 8'd30);
		settle();
		gaps_on = 1'b1;
	endtask

	// Mostly well-formed packets with random content; the rest is abandoned
	// packets, stray words and fully random words.
	task automatic random_phase(input int target);
		int         sent;
		int         r;
		int         n;
		int         d;
		logic [7:0] first;
		logic [7:0] declared;
		logic [7:0] b;
		logic [7:0] junk_len;
		logic       sop;
		logic       eop;
		sent = 0;
		while (sent < target) begin
			r = $urandom_range(99);
			n = ($urandom_range(9) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
			if ($urandom_range(99) < 85) begin
				first = magic_reg;
			end else begin
				first = 8'($urandom_range(255));
			end
			d = $urandom_range(99);
			if (d < 75) begin
				declared = 8'(n);
			end else if (d < 85) begin
				declared = 8'd255;
			end else if (d < 92) begin
				declared = 8'd0;
			end else begin
				declared = 8'($urandom_range(255));
			end
			b        = 8'($urandom_range(255));
			junk_len = 8'($urandom_range(255));
			if (r < 70) begin
				send_packet(first, n, declared);
				sent += n;
			end else if (r < 80) begin
				// stray word; it only counts if a packet happens to be open
				if (in_pkt) begin
					sent++;
				end
				eop = 1'($urandom_range(1));
				send_byte(mk_item(b, 1'b0, eop, junk_len));
			end else if (r < 92) begin
				// leave the packet open; the next start abandons it
				send_byte(mk_item(first, 1'b1, 1'b0, declared));
				for (int k = 1; k < n; k++) begin
					b        = 8'($urandom_range(255));
					junk_len = 8'($urandom_range(255));
					send_byte(mk_item(b, 1'b0, 1'b0, junk_len));
				end
				sent += n;
			end else begin
				sop = 1'($urandom_range(1));
				eop = 1'($urandom_range(1));
				send_byte(mk_item(b, sop, eop, junk_len));
				sent++;
			end
		end
		// close any open packet before the registers change
		if (in_pkt) begin
			b        = 8'($urandom_range(255));
			junk_len = 8'($urandom_range(255));
			send_byte(mk_item(b, 1'b0, 1'b1, junk_len));
		end
	endtask

	task automatic check_random_traffic();
		logic [7:0] magic;
		logic [7:0] min_len;
		configure(8'h00, 8'd1);
		random_phase(15);
		// stretch with no idling on either side
		gaps_on = 1'b0;
		configure(8'hFF, 8'd0);
		random_phase(15);
		gaps_on = 1'b1;
		magic   = 8'($urandom_range(255));
		min_len = 8'($urandom_range(1, 16));
		configure(magic, min_len);
		random_phase(15);
		configure(8'h5A, 8'd255);
		random_phase(10);
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin : stimulus
		push      <= 1'b0;
		item      <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		arst_n    <= 1'b0;

		magic_reg   = MAGIC_RESET;
		min_len_reg = MIN_LEN_RESET;
		crc_acc     = 8'h00;
		drop_pkt    = 1'b0;
		in_pkt      = 1'b0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		check_reset_settings();
		check_single_byte_frames();
		check_abandoned_packet();
		check_stray_bytes();
		check_length_mismatch();
		check_zero_minimum();
		check_field_extremes();
		check_backpressure();
		check_random_traffic();

		// drain, then give late or extra words a chance to show
		settle();
		repeat (20) @(posedge clk);

		if (errors == 0 && expected_words.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin : watchdog
		#(RUN_LIMIT);
		$display("TB_ERROR");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/pfcf_pkg.sv
rtl/core/pfcf_front.sv
rtl/core/pfcf_queue.sv
rtl/core/pfcf_back.sv
rtl/core/packet_filter_crc8_framer_core.sv
tb/tb_packet_filter_crc8_framer_core.sv
